/* rtl/core/ght_pkg.sv */
// Package for the generational handle table: parameter defaults, operation and
// error codes, and the controller state type.
// No dependencies; every module of the block imports it.
package ght_pkg;

    // Default table geometry.
    localparam int SLOTS_DEF    = 64;
    localparam int GEN_BITS_DEF = 16;

    // Widest word of the free map, which is scanned one word per cycle.
    localparam int MAP_W_MAX    = 32;

    // Operation codes carried in the input tuser.
    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_LOOKUP  = 2'd2
    } t_mode;

    // Error codes returned with each result.
    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_FULL = 2'd1,
        ERR_BAD  = 2'd2
    } t_err;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_A_HINT,
        ST_A_SCAN,
        ST_A_GEN,
        ST_CHECK,
        ST_RESP
    } t_state;

endpackage

/* rtl/core/ght_store.sv */
// Slot storage: the slot entry memory and the free map memory, both with registered
// read data, plus the clearing sweep that runs after reset.
// Depends on ght_pkg.
module ght_store
    import ght_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int GEN_BITS = GEN_BITS_DEF,
    localparam int IDX_W     = $clog2(SLOTS),
    localparam int MAP_W     = (SLOTS >= MAP_W_MAX) ? MAP_W_MAX : (1 << IDX_W),
    localparam int BW        = $clog2(MAP_W),
    localparam int MAP_DEPTH = (SLOTS + MAP_W - 1) / MAP_W,
    localparam int WA_W      = (IDX_W > BW) ? (IDX_W - BW) : 1,
    localparam int ENT_W     = GEN_BITS + 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    output logic             o_busy,
    // Entry fields from the lowest bit up: used, generation, access kind, predefined.
    input  logic [IDX_W-1:0] i_ent_addr,
    input  logic             i_ent_we,
    input  logic [ENT_W-1:0] i_ent_wdata,
    output logic [ENT_W-1:0] o_ent_rdata,
    // One map bit per slot: set while the slot is free and not retired.
    input  logic [WA_W-1:0]  i_map_addr,
    input  logic             i_map_we,
    input  logic [MAP_W-1:0] i_map_wdata,
    output logic [MAP_W-1:0] o_map_rdata
);

    localparam logic [GEN_BITS-1:0] GEN_INIT = GEN_BITS'(1);

    logic [ENT_W-1:0] r_ent_mem [SLOTS];
    logic [MAP_W-1:0] r_map_mem [MAP_DEPTH];

    logic [IDX_W-1:0] r_clr_cnt;
    logic             r_busy;

    logic [ENT_W-1:0] ent_wdata;
    logic [IDX_W-1:0] ent_waddr;
    logic             ent_we;
    logic [MAP_W-1:0] map_wdata;
    logic [WA_W-1:0]  map_waddr;
    logic             map_we;
    logic [MAP_W-1:0] clr_word;

    assign o_busy = r_busy;

    // Initial map word for the word being cleared: only slots that exist are takeable.
    always_comb begin
        for (int b = 0; b < MAP_W; b++) begin
            clr_word[b] = ((32'(r_clr_cnt) * 32'(MAP_W) + 32'(b)) < 32'(SLOTS));
        end
    end

    // The sweep owns both write ports until it is done.
    always_comb begin
        if (r_busy) begin
            ent_we    = 1'b1;
            ent_waddr = r_clr_cnt;
            ent_wdata = {1'b0, 2'b00, GEN_INIT, 1'b0};
            map_we    = (32'(r_clr_cnt) < 32'(MAP_DEPTH));
            map_waddr = WA_W'(r_clr_cnt);
            map_wdata = clr_word;
        end else begin
            ent_we    = i_ent_we;
            ent_waddr = i_ent_addr;
            ent_wdata = i_ent_wdata;
            map_we    = i_map_we;
            map_waddr = i_map_addr;
            map_wdata = i_map_wdata;
        end
    end

    // Clearing sweep, one entry per cycle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_busy) begin
            if (r_clr_cnt == IDX_W'(SLOTS - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // Slot entry memory.
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_mem[ent_waddr] <= ent_wdata;
        end
        o_ent_rdata <= r_ent_mem[i_ent_addr];
    end

    // Free map memory.
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_waddr] <= map_wdata;
        end
        o_map_rdata <= r_map_mem[i_map_addr];
    end

endmodule

/* rtl/core/generational_handle_table_top.sv */
// Generational handle table: allocate, release and look up slot handles.
// Allocate reads the map word of its hint slot and, when that slot is not takeable,
// scans the free map word by word; release and lookup check the handle's slot entry;
// an all-zero or out-of-range handle or the unused mode is rejected with no entry check; one item in flight at a time.
// Reset is synchronous and active low; after it the storage clears every slot entry,
// during which no input transaction is taken.
module generational_handle_table_top
    import ght_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int GEN_BITS = GEN_BITS_DEF,
    localparam int IDX_W  = $clog2(SLOTS),
    localparam int IN_RAW = IDX_W + GEN_BITS + 3,
    localparam int IN_DW  = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_DW = IN_DW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // Fields from bit 0: handle_index, handle_generation, access_kind, predefined.
    input  logic [IN_DW-1:0]  s_axis_tdata,
    // Fields from bit 0: mode.
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // Fields from bit 0: out_index, out_generation, access_kind_out, predefined_out.
    output logic [OUT_DW-1:0] m_axis_tdata,
    // Fields from bit 0: ok, error_code.
    output logic [2:0]        m_axis_tuser
);

    localparam int MAP_W     = (SLOTS >= MAP_W_MAX) ? MAP_W_MAX : (1 << IDX_W);
    localparam int BW        = $clog2(MAP_W);
    localparam int MAP_DEPTH = (SLOTS + MAP_W - 1) / MAP_W;
    localparam int WA_W      = (IDX_W > BW) ? (IDX_W - BW) : 1;
    localparam int ENT_W     = GEN_BITS + 4;
    localparam int HINT_W    = IDX_W + 1;
    localparam logic [GEN_BITS-1:0] GEN_MAX = {GEN_BITS{1'b1}};

    t_state r_state, n_state;

    logic [1:0]          r_mode;
    logic [GEN_BITS-1:0] r_hgen;
    logic [1:0]          r_acc;
    logic                r_pre;
    logic [HINT_W-1:0]   r_hint, n_hint;
    logic [IDX_W-1:0]    r_sel, n_sel;
    logic [MAP_W-1:0]    r_word, n_word;
    logic [WA_W-1:0]     r_waddr;

    logic                r_res_ok, n_res_ok;
    t_err                r_res_err, n_res_err;
    logic [IDX_W-1:0]    r_res_idx, n_res_idx;
    logic [GEN_BITS-1:0] r_res_gen, n_res_gen;
    logic [1:0]          r_res_acc, n_res_acc;
    logic                r_res_pre, n_res_pre;

    logic                r_m_valid;
    logic [OUT_DW-1:0]   r_m_data;
    logic [2:0]          r_m_user;

    logic [IDX_W-1:0]    ent_addr;
    logic                ent_we;
    logic [ENT_W-1:0]    ent_wdata;
    logic [ENT_W-1:0]    ent_q;
    logic [WA_W-1:0]     map_addr;
    logic                map_we;
    logic [MAP_W-1:0]    map_wdata;
    logic [MAP_W-1:0]    map_q;
    logic                busy;

    logic [IDX_W-1:0]    in_idx;
    logic [GEN_BITS-1:0] in_gen;
    logic [1:0]          in_acc;
    logic                in_pre;
    logic                s_fire;
    logic                in_bad;
    logic                out_free;

    logic                ent_used;
    logic [GEN_BITS-1:0] ent_gen;
    logic [1:0]          ent_acc;
    logic                ent_pre;
    logic [GEN_BITS-1:0] gen_next;

    logic                hint_in;
    logic                hint_hit;
    logic [MAP_W-1:0]    low_bit;
    logic [BW-1:0]       scan_pos;
    logic                scan_hit;
    logic                scan_last;
    logic                chk_ok;
    logic [MAP_W-1:0]    sel_onehot;

    ght_store #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_busy      (busy),
        .i_ent_addr  (ent_addr),
        .i_ent_we    (ent_we),
        .i_ent_wdata (ent_wdata),
        .o_ent_rdata (ent_q),
        .i_map_addr  (map_addr),
        .i_map_we    (map_we),
        .i_map_wdata (map_wdata),
        .o_map_rdata (map_q)
    );

    // Input fields.
    assign in_idx = s_axis_tdata[IDX_W-1:0];
    assign in_gen = s_axis_tdata[IDX_W +: GEN_BITS];
    assign in_acc = s_axis_tdata[IDX_W + GEN_BITS +: 2];
    assign in_pre = s_axis_tdata[IDX_W + GEN_BITS + 2];

    assign s_axis_tready = (r_state == ST_IDLE) && !busy;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    // A handle that fails before any memory read: out of range or all zero.
    assign in_bad = ({1'b0, in_idx} >= HINT_W'(SLOTS)) ||
                    ((in_idx == '0) && (in_gen == '0));

    // Fields of the entry read in the previous cycle.
    assign ent_used = ent_q[0];
    assign ent_gen  = ent_q[GEN_BITS:1];
    assign ent_acc  = ent_q[GEN_BITS+2:GEN_BITS+1];
    assign ent_pre  = ent_q[GEN_BITS+3];
    assign gen_next = (ent_gen != GEN_MAX) ? GEN_BITS'(ent_gen + 1'b1) : ent_gen;
    assign chk_ok   = ent_used && (ent_gen == r_hgen);

    // Hint check against the map word read at accept time.
    assign hint_in  = (r_hint < HINT_W'(SLOTS));
    assign hint_hit = hint_in && map_q[r_hint[BW-1:0]];

    // Lowest set bit of the scanned map word, isolated and then encoded.
    assign low_bit   = map_q & (~map_q + 1'b1);
    assign scan_hit  = (map_q != '0);
    assign scan_last = (r_waddr == WA_W'(MAP_DEPTH - 1));

    always_comb begin
        scan_pos = '0;
        for (int b = 0; b < MAP_W; b++) begin
            scan_pos = scan_pos | (low_bit[b] ? BW'(b) : '0);
        end
    end

    assign sel_onehot = MAP_W'(1) << r_sel[BW-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_axis_tuser)
                        MODE_ALLOC:   n_state = ST_A_HINT;
                        MODE_RELEASE,
                        MODE_LOOKUP:  n_state = in_bad ? ST_RESP : ST_CHECK;
                        default:      n_state = ST_RESP;
                    endcase
                end
            end
            ST_A_HINT: n_state = hint_hit ? ST_A_GEN : ST_A_SCAN;
            ST_A_SCAN: begin
                if (scan_hit) begin
                    n_state = ST_A_GEN;
                end else if (scan_last) begin
                    n_state = ST_RESP;
                end
            end
            ST_A_GEN:  n_state = ST_RESP;
            ST_CHECK:  n_state = ST_RESP;
            ST_RESP:   n_state = out_free ? ST_IDLE : ST_RESP;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Memory accesses and result values per state.
    always_comb begin
        ent_addr  = r_sel;
        ent_we    = 1'b0;
        ent_wdata = ent_q;
        map_addr  = r_waddr;
        map_we    = 1'b0;
        map_wdata = r_word;
        n_sel     = r_sel;
        n_word    = r_word;
        n_hint    = r_hint;
        n_res_ok  = r_res_ok;
        n_res_err = r_res_err;
        n_res_idx = r_res_idx;
        n_res_gen = r_res_gen;
        n_res_acc = r_res_acc;
        n_res_pre = r_res_pre;
        case (r_state)
            ST_IDLE: begin
                // Read the hint's map word for allocate, the handle's entry otherwise.
                if (s_axis_tuser == MODE_ALLOC) begin
                    map_addr = hint_in ? WA_W'(r_hint >> BW) : '0;
                end else begin
                    map_addr = WA_W'(in_idx >> BW);
                end
                ent_addr = in_idx;
                n_sel    = in_idx;
                // Preset a rejection; later states overwrite it on success.
                n_res_ok  = 1'b0;
                n_res_err = ERR_BAD;
                n_res_idx = '0;
                n_res_gen = '0;
                n_res_acc = '0;
                n_res_pre = 1'b0;
            end
            ST_A_HINT: begin
                if (hint_hit) begin
                    n_sel    = r_hint[IDX_W-1:0];
                    ent_addr = r_hint[IDX_W-1:0];
                    n_word   = map_q;
                end else begin
                    map_addr = '0;
                end
            end
            ST_A_SCAN: begin
                if (scan_hit) begin
                    n_sel    = IDX_W'({r_waddr, scan_pos});
                    ent_addr = IDX_W'({r_waddr, scan_pos});
                    n_word   = map_q;
                end else if (scan_last) begin
                    n_res_err = ERR_FULL;
                end else begin
                    map_addr = r_waddr + 1'b1;
                end
            end
            ST_A_GEN: begin
                // Claim the slot and take it out of the free map.
                ent_we    = 1'b1;
                ent_wdata = {r_pre, r_acc, ent_gen, 1'b1};
                map_we    = 1'b1;
                map_wdata = r_word & ~sel_onehot;
                n_hint    = HINT_W'(r_sel) + 1'b1;
                n_res_ok  = 1'b1;
                n_res_err = ERR_NONE;
                n_res_idx = r_sel;
                n_res_gen = ent_gen;
            end
            ST_CHECK: begin
                if (chk_ok) begin
                    n_res_ok  = 1'b1;
                    n_res_err = ERR_NONE;
                    n_res_acc = ent_acc;
                    n_res_pre = ent_pre;
                    if (r_mode == MODE_RELEASE) begin
                        // Free the slot; it stays out of the map once retired.
                        ent_we    = 1'b1;
                        ent_wdata = {ent_pre, ent_acc, gen_next, 1'b0};
                        map_we    = 1'b1;
                        map_wdata = map_q | ((gen_next != GEN_MAX) ? sel_onehot : '0);
                        n_hint    = HINT_W'(r_sel);
                    end else begin
                        n_res_idx = r_sel;
                        n_res_gen = ent_gen;
                    end
                end
            end
            ST_RESP: begin
                n_sel = r_sel;
            end
            default: begin
                n_sel = r_sel;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_hint    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hint  <= n_hint;
            if ((r_state == ST_RESP) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_mode <= s_axis_tuser;
            r_hgen <= in_gen;
            r_acc  <= in_acc;
            r_pre  <= in_pre;
        end
        r_sel     <= n_sel;
        r_word    <= n_word;
        r_waddr   <= map_addr;
        r_res_ok  <= n_res_ok;
        r_res_err <= n_res_err;
        r_res_idx <= n_res_idx;
        r_res_gen <= n_res_gen;
        r_res_acc <= n_res_acc;
        r_res_pre <= n_res_pre;
        if ((r_state == ST_RESP) && out_free) begin
            r_m_data <= OUT_DW'({r_res_pre, r_res_acc, r_res_gen, r_res_idx});
            r_m_user <= {r_res_err, r_res_ok};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

/* bench/handle_table_checker.sv */
// Checker for the generational handle table: watches both stream channels,
// predicts every reply from its own copy of the slot table and compares.
// Depends on ght_pkg for the geometry defaults, operation and error codes.
module handle_table_checker
    import ght_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int GEN_BITS = GEN_BITS_DEF,
    localparam int IDX_W   = $clog2(SLOTS),
    localparam int DW      = ((IDX_W + GEN_BITS + 3 + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tready,
    // Fields from bit 0: handle_index, handle_generation, access_kind, predefined.
    input  logic [DW-1:0] i_s_tdata,
    // Fields from bit 0: mode.
    input  logic [1:0]    i_s_tuser,
    input  logic          i_m_tvalid,
    input  logic          i_m_tready,
    // Fields from bit 0: out_index, out_generation, access_kind_out, predefined_out.
    input  logic [DW-1:0] i_m_tdata,
    // Fields from bit 0: ok, error_code.
    input  logic [2:0]    i_m_tuser,
    output int            o_error_count,
    output int            o_pending,
    output int            o_result_count,
    output int            o_full_count,
    output int            o_reject_count,
    output int            o_retire_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KIND_LSB = IDX_W + GEN_BITS;
    localparam int STD_BIT  = KIND_LSB + 2;
    localparam logic [GEN_BITS-1:0] GEN_TOP = '1;

    // One reply of the table, as the block should send it.
    typedef struct packed {
        logic                ok;
        t_err                err;
        logic [IDX_W-1:0]    idx;
        logic [GEN_BITS-1:0] gen;
        logic [1:0]          kind;
        logic                std;
    } t_slot_reply;

    // Shadow of the slot table.
    logic                slot_live [SLOTS];
    logic [GEN_BITS-1:0] slot_gen  [SLOTS];
    logic [1:0]          slot_kind [SLOTS];
    logic                slot_std  [SLOTS];
    logic [IDX_W:0]      alloc_hint;

    // Replies owed by the block, oldest first.
    t_slot_reply owed_replies [$];

    int n_errors;
    int n_owed;
    int n_results;
    int n_full;
    int n_reject;
    int n_retired;

    assign o_error_count  = n_errors;
    assign o_pending      = n_owed;
    assign o_result_count = n_results;
    assign o_full_count   = n_full;
    assign o_reject_count = n_reject;
    assign o_retire_count = n_retired;

    // Prints one line per mismatch (up to a cap) and counts every one.
    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        n_errors++;
        if (n_errors <= 40) begin
            $display("MISMATCH at %0t, reply %0d, %s: expected 0x%0h, got 0x%0h",
                     $realtime, n_results, what, want, got);
        end
    endtask

    // A slot can be handed out when it is free and not retired.
    function automatic logic takeable(input int slot);
        return !slot_live[slot] && slot_gen[slot] != GEN_TOP;
    endfunction

    function automatic logic handle_good(input logic [IDX_W-1:0] hidx,
                                         input logic [GEN_BITS-1:0] hgen);
        if (hidx == '0 && hgen == '0) begin
            return 1'b0;
        end
        if (int'(hidx) >= SLOTS) begin
            return 1'b0;
        end
        if (!slot_live[hidx]) begin
            return 1'b0;
        end
        return slot_gen[hidx] == hgen;
    endfunction

    // Applies one request to the shadow table and returns the reply it earns.
    function automatic t_slot_reply table_answer(input logic [1:0] mode,
                                                 input logic [IDX_W-1:0] hidx,
                                                 input logic [GEN_BITS-1:0] hgen,
                                                 input logic [1:0] kind,
                                                 input logic std);
        t_slot_reply r;
        int pick;
        int i;
        r = '0;
        r.err = ERR_BAD;
        pick = SLOTS;
        case (mode)
            MODE_ALLOC: begin
                // Hint first; otherwise the lowest takeable slot.
                if (int'(alloc_hint) < SLOTS && takeable(int'(alloc_hint))) begin
                    pick = int'(alloc_hint);
                end else begin
                    for (i = SLOTS - 1; i >= 0; i--) begin
                        if (takeable(i)) begin
                            pick = i;
                        end
                    end
                end
                if (pick == SLOTS) begin
                    r.err = ERR_FULL;
                end else begin
                    slot_live[pick] = 1'b1;
                    slot_kind[pick] = kind;
                    slot_std[pick]  = std;
                    alloc_hint      = (IDX_W + 1)'(pick + 1);
                    r.ok  = 1'b1;
                    r.err = ERR_NONE;
                    r.idx = IDX_W'(pick);
                    r.gen = slot_gen[pick];
                end
            end
            MODE_RELEASE: begin
                if (handle_good(hidx, hgen)) begin
                    r.kind = slot_kind[hidx];
                    r.std  = slot_std[hidx];
                    slot_live[hidx] = 1'b0;
                    // A generation that reaches all ones retires its slot.
                    if (slot_gen[hidx] != GEN_TOP) begin
                        slot_gen[hidx] = slot_gen[hidx] + 1'b1;
                        if (slot_gen[hidx] == GEN_TOP) begin
                            n_retired++;
                        end
                    end
                    alloc_hint = {1'b0, hidx};
                    r.ok  = 1'b1;
                    r.err = ERR_NONE;
                end
            end
            MODE_LOOKUP: begin
                if (handle_good(hidx, hgen)) begin
                    r.idx  = hidx;
                    r.gen  = slot_gen[hidx];
                    r.kind = slot_kind[hidx];
                    r.std  = slot_std[hidx];
                    r.ok   = 1'b1;
                    r.err  = ERR_NONE;
                end
            end
            default: begin
                // The unused mode is rejected like a bad handle.
            end
        endcase
        return r;
    endfunction

    // Compares one reply from the block with the oldest owed one.
    task automatic check_reply();
        t_slot_reply want;
        n_results++;
        if (owed_replies.size() == 0) begin
            flag_mismatch("reply with no request outstanding", 32'd0, 32'(i_m_tuser));
            return;
        end
        want = owed_replies.pop_front();
        n_owed--;
        if (want.err == ERR_FULL) begin
            n_full++;
        end
        if (want.err == ERR_BAD) begin
            n_reject++;
        end
        if (i_m_tuser[0] !== want.ok) begin
            flag_mismatch("ok", 32'(want.ok), 32'(i_m_tuser[0]));
        end
        if (i_m_tuser[2:1] !== want.err) begin
            flag_mismatch("error_code", 32'(want.err), 32'(i_m_tuser[2:1]));
        end
        if (i_m_tdata[IDX_W-1:0] !== want.idx) begin
            flag_mismatch("out_index", 32'(want.idx), 32'(i_m_tdata[IDX_W-1:0]));
        end
        if (i_m_tdata[IDX_W +: GEN_BITS] !== want.gen) begin
            flag_mismatch("out_generation", 32'(want.gen),
                          32'(i_m_tdata[IDX_W +: GEN_BITS]));
        end
        if (i_m_tdata[KIND_LSB +: 2] !== want.kind) begin
            flag_mismatch("access_kind_out", 32'(want.kind), 32'(i_m_tdata[KIND_LSB +: 2]));
        end
        if (i_m_tdata[STD_BIT] !== want.std) begin
            flag_mismatch("predefined_out", 32'(want.std), 32'(i_m_tdata[STD_BIT]));
        end
    endtask

    // Replies are checked before the request of the same edge is predicted;
    // the block keeps only one item in flight.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (slot_live[k]) begin
                slot_live[k] = 1'b0;
                slot_gen[k]  = GEN_BITS'(1);
                slot_kind[k] = 2'd0;
                slot_std[k]  = 1'b0;
            end
            alloc_hint = '0;
            owed_replies.delete();
            n_owed = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_reply();
            end
            if (i_s_tvalid && i_s_tready) begin
                owed_replies.push_back(table_answer(i_s_tuser,
                                                    i_s_tdata[IDX_W-1:0],
                                                    i_s_tdata[IDX_W +: GEN_BITS],
                                                    i_s_tdata[KIND_LSB +: 2],
                                                    i_s_tdata[STD_BIT]));
                n_owed++;
            end
        end
    end

endmodule

/* bench/tb_generational_handle_table_top.sv */
// Testbench top for the generational handle table: clock, reset, stimulus and verdict.
// Depends on ght_pkg, generational_handle_table_top and handle_table_checker.
module tb_generational_handle_table_top;
    import ght_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT  = SLOTS_DEF;
    localparam int IDX_W  = $clog2(NSLOT);
    localparam int GEN_W  = GEN_BITS_DEF;
    localparam int DW     = ((IDX_W + GEN_W + 3 + 7) / 8) * 8;
    localparam int PAD_W  = DW - (IDX_W + GEN_W + 3);
    localparam int GEN_TOP = (1 << GEN_W) - 1;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_PER_PHASE = 540;
    localparam int REUSE_ROUNDS     = 8;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int DRAIN_CYCLES     = 32;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
    } t_handle;

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    // Fields from bit 0: handle_index, handle_generation, access_kind, predefined.
    logic [DW-1:0] s_axis_tdata  = '0;
    // Fields from bit 0: mode.
    logic [1:0]    s_axis_tuser  = MODE_LOOKUP;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    // Fields from bit 0: out_index, out_generation, access_kind_out, predefined_out.
    logic [DW-1:0] m_axis_tdata;
    // Fields from bit 0: ok, error_code.
    logic [2:0]    m_axis_tuser;

    int n_errors;
    int n_waiting;
    int n_results;
    int n_full;
    int n_reject;
    int n_retired;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;

    // Handles the block has handed out and not yet been asked to release,
    // and a short history of released ones for stale-handle requests.
    t_handle    live_q  [$];
    t_handle    stale_q [$];
    logic [1:0] sent_modes [$];

    generational_handle_table_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    handle_table_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_s_tuser      (s_axis_tuser),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .i_m_tuser      (m_axis_tuser),
        .o_error_count  (n_errors),
        .o_pending      (n_waiting),
        .o_result_count (n_results),
        .o_full_count   (n_full),
        .o_reject_count (n_reject),
        .o_retire_count (n_retired)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver stalls at random at the current rate.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Learn handed-out handles from the replies, and watch for a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sent_modes.delete();
            live_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready && sent_modes.size() != 0) begin
                if (sent_modes.pop_front() == MODE_ALLOC && m_axis_tuser[0]) begin
                    live_q.push_back({m_axis_tdata[IDX_W-1:0], m_axis_tdata[IDX_W +: GEN_W]});
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sent_modes.push_back(s_axis_tuser);
            end
        end
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d replies outstanding.",
                     WATCHDOG_LIMIT, n_waiting);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_handle handle_of(input int idx, input int gen);
        t_handle h;
        h.idx = IDX_W'(idx);
        h.gen = GEN_W'(gen);
        return h;
    endfunction

    // Presents one request and holds it until the block takes it.
    task automatic drive_op(input logic [1:0] mode, input t_handle h,
                            input logic [1:0] kind, input logic std);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {{PAD_W{1'b0}}, std, kind, h.gen, h.idx};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // Drops the request line and waits until every reply is back.
    task automatic settle_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (n_waiting != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic pick_live(output t_handle h, output bit found);
        settle_results();
        found = (live_q.size() != 0);
        h = found ? live_q[$urandom_range(live_q.size() - 1)] : handle_of(0, 0);
    endtask

    task automatic release_handle(input t_handle h);
        int k;
        for (k = live_q.size() - 1; k >= 0; k--) begin
            if (live_q[k] == h) begin
                live_q.delete(k);
            end
        end
        stale_q.push_back(h);
        if (stale_q.size() > 32) begin
            stale_q.delete(0);
        end
        drive_op(MODE_RELEASE, h, 2'($urandom), 1'($urandom));
    endtask

    // Mostly well-formed handle traffic, with noise and stale handles mixed in.
    task automatic random_item(input int alloc_pct);
        t_handle h;
        bit found;
        int r;
        r = $urandom_range(99);
        h = handle_of($urandom, $urandom);
        if (r < 4) begin
            drive_op(MODE_UNUSED, h, 2'($urandom), 1'($urandom));
        end else if (r < 12) begin
            drive_op(($urandom_range(1) == 1) ? MODE_RELEASE : MODE_LOOKUP, h,
                     2'($urandom), 1'($urandom));
        end else if (r < 20) begin
            // Stale handle, or a live one with one generation bit flipped.
            if (stale_q.size() != 0 && $urandom_range(1) == 1) begin
                h = stale_q[$urandom_range(stale_q.size() - 1)];
            end else begin
                pick_live(h, found);
                h.gen[$urandom_range(GEN_W - 1)] ^= 1'b1;
            end
            drive_op(($urandom_range(1) == 1) ? MODE_RELEASE : MODE_LOOKUP, h,
                     2'($urandom), 1'($urandom));
        end else if ($urandom_range(99) < alloc_pct) begin
            drive_op(MODE_ALLOC, h, 2'($urandom), 1'($urandom));
        end else begin
            pick_live(h, found);
            if (!found) begin
                drive_op(MODE_ALLOC, h, 2'($urandom), 1'($urandom));
            end else if ($urandom_range(1) == 1) begin
                release_handle(h);
            end else begin
                drive_op(MODE_LOOKUP, h, 2'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        t_handle h;
        int k;
        int g;

        // Hold reset, then release it; the block then clears its table by itself.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles rarely, receiver often.
        send_idle_pct = 12;
        recv_idle_pct = 66;

        // Rejections on an empty table: all-zero handle, unused mode, free slot.
        drive_op(MODE_LOOKUP, handle_of(0, 0), 2'd0, 1'b0);
        drive_op(MODE_RELEASE, handle_of(0, 0), 2'd0, 1'b0);
        drive_op(MODE_UNUSED, handle_of(NSLOT - 1, GEN_TOP), 2'd3, 1'b1);
        drive_op(MODE_LOOKUP, handle_of(5, 1), 2'd0, 1'b0);

        // Allocate slots 0 to 4 with every access kind.
        for (k = 0; k < 5; k++) begin
            drive_op(MODE_ALLOC, handle_of(0, 0), k[1:0], k[0]);
        end
        settle_results();
        drive_op(MODE_LOOKUP, handle_of(4, 1), 2'd0, 1'b0);
        drive_op(MODE_LOOKUP, handle_of(4, GEN_TOP), 2'd0, 1'b0);
        drive_op(MODE_LOOKUP, handle_of(0, 1), 2'd0, 1'b0);

        // Release, double release, and reuse through the hint.
        release_handle(handle_of(2, 1));
        drive_op(MODE_RELEASE, handle_of(2, 1), 2'd0, 1'b0);
        drive_op(MODE_ALLOC, handle_of(0, 0), 2'd3, 1'b1);
        release_handle(handle_of(1, 1));
        release_handle(handle_of(3, 1));
        drive_op(MODE_ALLOC, handle_of(0, 0), 2'd2, 1'b0);
        // The hint now points at a busy slot, so this one scans.
        drive_op(MODE_ALLOC, handle_of(0, 0), 2'd1, 1'b1);
        drive_op(MODE_LOOKUP, handle_of(2, 1), 2'd0, 1'b0);
        drive_op(MODE_LOOKUP, handle_of(2, 2), 2'd0, 1'b0);

        // Random traffic that drifts toward a full table.
        for (k = 0; k < RANDOM_PER_PHASE; k++) begin
            random_item(50);
        end

        // Sender idles often, receiver rarely; traffic drifts toward empty.
        send_idle_pct = 66;
        recv_idle_pct = 12;
        for (k = 0; k < RANDOM_PER_PHASE; k++) begin
            random_item(30);
        end

        // No idling from here on.
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Empty the table, then reuse one slot through the hint a few times.
        settle_results();
        while (live_q.size() != 0) begin
            release_handle(live_q[0]);
        end
        drive_op(MODE_ALLOC, handle_of(0, 0), 2'($urandom), 1'($urandom));
        settle_results();
        if (live_q.size() != 0) begin
            h = live_q[0];
            release_handle(h);
            g = int'(h.gen) + 1;
            for (k = 0; k < REUSE_ROUNDS && g < GEN_TOP; k++) begin
                drive_op(MODE_ALLOC, handle_of(0, 0), 2'($urandom), 1'($urandom));
                drive_op(MODE_RELEASE, handle_of(int'(h.idx), g), 2'($urandom),
                         1'($urandom));
                g++;
            end
            settle_results();
            live_q.delete();
            // The slot is free now: its current generation and the one before are refused.
            drive_op(MODE_LOOKUP, handle_of(int'(h.idx), g), 2'd0, 1'b0);
            drive_op(MODE_RELEASE, handle_of(int'(h.idx), g - 1), 2'd0, 1'b0);
        end

        // Fill every takeable slot, then ask for one more so the table answers full.
        for (k = 0; k <= NSLOT; k++) begin
            drive_op(MODE_ALLOC, handle_of(0, 0), 2'($urandom), 1'($urandom));
        end
        for (k = 0; k < 40; k++) begin
            random_item(40);
        end

        // Let the last replies come back.
        settle_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d replies: %0d table-full answers, %0d rejected requests.",
                 n_results, n_full, n_reject);
        $display("Traffic ran under both stall patterns and then unthrottled; %0d slots retired.",
                 n_retired);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
